>>> rtl/core/sql_like_wildcard_matcher_top_defines.svh
// Assertion macros shared by the SQL LIKE matcher RTL.
`ifndef SQL_LIKE_WILDCARD_MATCHER_TOP_DEFINES_SVH
`define SQL_LIKE_WILDCARD_MATCHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define SLWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slwm check failed");
// Next-cycle implication, disabled in reset.
`define SLWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slwm check failed");
`else
`define SLWM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/slwm_pkg.sv
// Types, codes and helper functions of the SQL LIKE matcher.
package slwm_pkg;

    // Default depth of the token store
    localparam int MAX_TOKENS_DEF = 64;

    // Input word opcodes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    // Token kinds
    localparam logic [1:0] KIND_LIT = 2'd0;
    localparam logic [1:0] KIND_ONE = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;

    // Pattern special bytes
    localparam logic [7:0] CH_RUN = 8'h25;
    localparam logic [7:0] CH_ONE = 8'h5F;
    localparam logic [7:0] CH_ESC = 8'h5C;

    // Fold ASCII upper case to lower case when enabled
    function automatic logic [7:0] fold_lower(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/slwm_in_if.sv
// Input channel: opcode, data byte and last flag with valid/ready.
interface slwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output opcode, output data_byte, output last, input ready);
    modport sink   (input valid, input opcode, input data_byte, input last, output ready);
endinterface

>>> rtl/core/slwm_out_if.sv
// Result channel: match and overflow flags with valid/ready.
interface slwm_out_if;
    logic valid;
    logic ready;
    logic match;
    logic pattern_too_long;

    modport source (output valid, output match, output pattern_too_long, input ready);
    modport sink   (input valid, input match, input pattern_too_long, output ready);
endinterface

>>> rtl/core/sql_like_wildcard_matcher_top.sv
// Top level of the SQL LIKE matcher: input register, token store, automaton, result register.
//
//  channel   dir  handshake       word
//  i_in      in   valid/ready     opcode[1:0], data_byte[7:0], last
//  o_out     out  valid/ready     match, pattern_too_long
//  apb       in   psel/penable    reg 0 ignore_case at byte address 0
//
// One word per cycle unless a word with a result waits on a stalled result register;
// the result register loads from the word in the input register once that word fires.
// The bit-parallel, combinational position update over all tokens sets the rate.
// Reset is synchronous; no clearing pass, the token store is only read below
// the token count. A stalled result holds the output register; words that
// yield no result still move while it waits.
`include "sql_like_wildcard_matcher_top_defines.svh"

module sql_like_wildcard_matcher_top #(
    parameter int MAX_TOKENS = slwm_pkg::MAX_TOKENS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slwm_in_if.sink      i_in,
    slwm_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int POS_N = MAX_TOKENS + 1;
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int IDX_W = $clog2(MAX_TOKENS);

    // Configuration
    logic r_ignore_case;

    // Input register
    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Pattern and text state
    logic [1:0]       r_tok_kind [MAX_TOKENS];
    logic [7:0]       r_tok_char [MAX_TOKENS];
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_lead, n_lead;
    logic             r_lead_all, n_lead_all;
    logic             r_esc, n_esc;
    logic             r_ovf, n_ovf;
    logic             r_tip, n_tip;
    logic [POS_N-1:0] r_active, n_active;

    // Result register
    logic r_out_valid;
    logic r_out_match;
    logic r_out_too_long;

    logic             has_res;
    logic             out_free;
    logic             fire;
    logic             res_match;
    logic             w_kind_en;
    logic             w_char_en;
    logic [IDX_W-1:0] w_idx;
    logic [1:0]       w_kind;
    logic [1:0]       new_kind;
    logic [CNT_W-1:0] cnt_m1;
    logic             room;
    logic [POS_N-1:0] start_act;
    logic [POS_N-1:0] cur_act;
    logic [POS_N-1:0] step_act;

    // APB register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_ignore_case} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_case <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_ignore_case <= pwdata[0];
        end
    end

    // Handshake control
    assign has_res  = (r_in_op == slwm_pkg::OP_QUERY) ||
                      ((r_in_op == slwm_pkg::OP_TEXT) && r_in_last);
    assign out_free = !r_out_valid || o_out.ready;
    assign fire     = r_in_valid && (!has_res || out_free);
    assign i_in.ready = !r_in_valid || fire;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.opcode;
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last;
        end
    end

    // Start set: position zero plus every position behind leading runs
    always_comb begin
        for (int i = 0; i < POS_N; i++) begin
            start_act[i] = (CNT_W'(i) <= r_lead);
        end
    end

    assign cur_act = r_tip ? r_active : start_act;

    slwm_nfa #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_nfa (
        .i_act   (cur_act),
        .i_kind  (r_tok_kind),
        .i_char  (r_tok_char),
        .i_count (r_count),
        .i_byte  (r_in_byte),
        .i_fold  (r_ignore_case),
        .o_act   (step_act)
    );

    // Classify an appended byte
    always_comb begin
        priority if (r_in_byte == slwm_pkg::CH_RUN) begin
            new_kind = slwm_pkg::KIND_RUN;
        end else if (r_in_byte == slwm_pkg::CH_ONE) begin
            new_kind = slwm_pkg::KIND_ONE;
        end else begin
            new_kind = slwm_pkg::KIND_LIT;
        end
    end

    assign cnt_m1 = r_count - 1'b1;
    assign room   = (r_count < CNT_W'(MAX_TOKENS));

    // Next state for the word in the input register
    always_comb begin
        n_count    = r_count;
        n_lead     = r_lead;
        n_lead_all = r_lead_all;
        n_esc      = r_esc;
        n_ovf      = r_ovf;
        n_tip      = r_tip;
        n_active   = r_active;
        w_kind_en  = 1'b0;
        w_char_en  = 1'b0;
        w_idx      = r_count[IDX_W-1:0];
        w_kind     = new_kind;
        res_match  = 1'b0;
        unique case (r_in_op)
            slwm_pkg::OP_CLEAR: begin
                n_count    = '0;
                n_lead     = '0;
                n_lead_all = 1'b1;
                n_esc      = 1'b0;
                n_ovf      = 1'b0;
                n_tip      = 1'b0;
            end
            slwm_pkg::OP_APPEND: begin
                n_tip = 1'b0;
                if (r_esc) begin
                    // replace the byte of the held backslash token
                    n_esc     = 1'b0;
                    w_idx     = cnt_m1[IDX_W-1:0];
                    w_char_en = (r_count != '0);
                end else if (!room) begin
                    n_ovf = 1'b1;
                end else begin
                    w_kind_en = 1'b1;
                    w_char_en = 1'b1;
                    n_count   = r_count + 1'b1;
                    if (r_in_byte == slwm_pkg::CH_ESC) begin
                        w_kind = slwm_pkg::KIND_LIT;
                        n_esc  = 1'b1;
                    end
                    if (r_lead_all && (w_kind == slwm_pkg::KIND_RUN)) begin
                        n_lead = r_lead + 1'b1;
                    end else if (w_kind != slwm_pkg::KIND_RUN) begin
                        n_lead_all = 1'b0;
                    end
                end
            end
            slwm_pkg::OP_TEXT: begin
                n_active  = step_act;
                n_tip     = !r_in_last;
                res_match = !r_ovf && step_act[r_count];
            end
            slwm_pkg::OP_QUERY: begin
                n_tip     = 1'b0;
                res_match = (r_count == '0) && !r_ovf;
            end
            default: begin
                n_tip = r_tip;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_lead     <= '0;
            r_lead_all <= 1'b1;
            r_esc      <= 1'b0;
            r_ovf      <= 1'b0;
            r_tip      <= 1'b0;
            r_active   <= POS_N'(1);
        end else if (fire) begin
            r_count    <= n_count;
            r_lead     <= n_lead;
            r_lead_all <= n_lead_all;
            r_esc      <= n_esc;
            r_ovf      <= n_ovf;
            r_tip      <= n_tip;
            r_active   <= n_active;
        end
    end

    // Token store
    always_ff @(posedge i_clk) begin
        if (fire && w_kind_en) begin
            r_tok_kind[w_idx] <= w_kind;
        end
        if (fire && w_char_en) begin
            r_tok_char[w_idx] <= r_in_byte;
        end
    end

    // Result register: load on a result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && has_res) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_res) begin
            r_out_match    <= res_match;
            r_out_too_long <= r_ovf;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.match            = r_out_match;
    assign o_out.pattern_too_long = r_out_too_long;

    // Checks
    `SLWM_ASSERT_NOW(a_ovf_no_match, i_clk, i_rst_n, o_out.valid && o_out.pattern_too_long, !o_out.match)
    `SLWM_ASSERT_NOW(a_lead_le_count, i_clk, i_rst_n, 1'b1, (r_lead <= r_count) && (r_count <= CNT_W'(MAX_TOKENS)))
    `SLWM_ASSERT_NOW(a_esc_has_token, i_clk, i_rst_n, r_esc, r_count != '0)
    `SLWM_ASSERT_NOW(a_take_when_full, i_clk, i_rst_n, i_in.valid && i_in.ready && r_in_valid, fire)
    `SLWM_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, fire && (r_in_op == slwm_pkg::OP_CLEAR), (r_count == '0) && !r_ovf && !r_esc)

endmodule

>>> rtl/core/slwm_nfa.sv
// One text byte step of the position-set automaton, with run closure.
module slwm_nfa #(
    parameter int MAX_TOKENS = slwm_pkg::MAX_TOKENS_DEF
) (
    input  logic [MAX_TOKENS:0]                   i_act,
    input  logic [1:0]                            i_kind [MAX_TOKENS],
    input  logic [7:0]                            i_char [MAX_TOKENS],
    input  logic [$clog2(MAX_TOKENS+1)-1:0]       i_count,
    input  logic [7:0]                            i_byte,
    input  logic                                  i_fold,
    output logic [MAX_TOKENS:0]                   o_act
);
    localparam int POS_N = MAX_TOKENS + 1;
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int LV    = $clog2(POS_N);

    logic [MAX_TOKENS-1:0] tok_valid;
    logic [MAX_TOKENS-1:0] stay;
    logic [MAX_TOKENS-1:0] adv;
    logic [POS_N-1:0]      nxt;
    logic [POS_N-1:0]      prop;
    logic [LV:0][POS_N-1:0] g_l;
    logic [LV:0][POS_N-1:0] p_l;
    logic [7:0]            byte_f;

    // Advance each live position by its token
    always_comb begin
        byte_f = slwm_pkg::fold_lower(i_byte, i_fold);
        for (int i = 0; i < MAX_TOKENS; i++) begin
            tok_valid[i] = (CNT_W'(i) < i_count);
            stay[i]      = 1'b0;
            adv[i]       = 1'b0;
            if (tok_valid[i] && i_act[i]) begin
                unique case (i_kind[i])
                    slwm_pkg::KIND_RUN: stay[i] = 1'b1;
                    slwm_pkg::KIND_ONE: adv[i]  = 1'b1;
                    slwm_pkg::KIND_LIT: adv[i]  =
                        (slwm_pkg::fold_lower(i_char[i], i_fold) == byte_f);
                    default:            adv[i]  = 1'b0;
                endcase
            end
        end
        nxt[0] = stay[0];
        for (int i = 1; i < MAX_TOKENS; i++) begin
            nxt[i] = stay[i] | adv[i-1];
        end
        nxt[MAX_TOKENS] = adv[MAX_TOKENS-1];
    end

    // Close over run tokens with a prefix network: a run may match nothing
    always_comb begin
        prop[0] = 1'b0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            prop[i+1] = tok_valid[i] && (i_kind[i] == slwm_pkg::KIND_RUN);
        end
        g_l[0] = nxt;
        p_l[0] = prop;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < POS_N; i++) begin
                if (i >= (1 << l)) begin
                    g_l[l+1][i] = g_l[l][i] | (p_l[l][i] & g_l[l][i-(1<<l)]);
                    p_l[l+1][i] = p_l[l][i] & p_l[l][i-(1<<l)];
                end else begin
                    g_l[l+1][i] = g_l[l][i];
                    p_l[l+1][i] = p_l[l][i];
                end
            end
        end
        o_act = g_l[LV];
    end

endmodule

>>> verif/tb.sv
// Self-checking testbench of the SQL LIKE wildcard matcher top level.
`timescale 1ns / 1ps

module tb;

    localparam int          MAXT        = slwm_pkg::MAX_TOKENS_DEF;
    localparam logic [2:0]  ADDR_FOLD   = 3'd0;
    localparam int          LATENCY     = 6;
    localparam int          DRAIN_LIMIT = 5000;

    typedef struct packed {
        logic match;
        logic too_long;
    } t_like_res;

    typedef logic [7:0] t_octet_q [$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slwm_in_if  in_if ();
    slwm_out_if out_if ();

    sql_like_wildcard_matcher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // Matcher state as predicted
    logic [1:0]  tk_kind [MAXT];
    logic [7:0]  tk_char [MAXT];
    int          tk_cnt;
    logic        esc_pend;
    logic        ovf_seen;
    logic        txt_busy;
    logic [MAXT:0] act_pos;
    logic        fold_en;

    t_like_res   match_q [$];
    t_octet_q    pat_q;
    int          n_err;
    int          sent_cnt;
    int          send_idle_pct;
    int          recv_stall_pct;

    function automatic logic [7:0] case_fold(input logic [7:0] c);
        if (fold_en && (c >= 8'h41) && (c <= 8'h5A)) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Let every active run token also match nothing
    function automatic void spread_runs();
        for (int i = 0; i < tk_cnt; i++) begin
            if (act_pos[i] && (tk_kind[i] == slwm_pkg::KIND_RUN)) begin
                act_pos[i + 1] = 1'b1;
            end
        end
    endfunction

    function automatic void restart_text();
        act_pos    = '0;
        act_pos[0] = 1'b1;
        spread_runs();
        txt_busy   = 1'b0;
    endfunction

    function automatic void add_token(input logic [1:0] kind, input logic [7:0] ch);
        if (tk_cnt >= MAXT) begin
            ovf_seen = 1'b1;
        end else begin
            tk_kind[tk_cnt] = kind;
            tk_char[tk_cnt] = ch;
            tk_cnt++;
        end
    endfunction

    function automatic void matcher_reset();
        fold_en  = 1'b0;
        tk_cnt   = 0;
        esc_pend = 1'b0;
        ovf_seen = 1'b0;
        restart_text();
    endfunction

    // Advance the predicted state by one accepted word
    function automatic void predict_word(input slwm_pkg::t_opcode op, input logic [7:0] b,
                                         input logic l);
        logic [MAXT:0] nxt;
        t_like_res     r;
        case (op)
            slwm_pkg::OP_CLEAR: begin
                tk_cnt   = 0;
                esc_pend = 1'b0;
                ovf_seen = 1'b0;
                restart_text();
            end
            slwm_pkg::OP_APPEND: begin
                if (esc_pend) begin
                    esc_pend = 1'b0;
                    if (tk_cnt > 0) begin
                        tk_char[tk_cnt - 1] = b;
                    end
                end else if (b == slwm_pkg::CH_ESC) begin
                    if (tk_cnt < MAXT) begin
                        add_token(slwm_pkg::KIND_LIT, b);
                        esc_pend = 1'b1;
                    end else begin
                        ovf_seen = 1'b1;
                    end
                end else if (b == slwm_pkg::CH_RUN) begin
                    add_token(slwm_pkg::KIND_RUN, b);
                end else if (b == slwm_pkg::CH_ONE) begin
                    add_token(slwm_pkg::KIND_ONE, b);
                end else begin
                    add_token(slwm_pkg::KIND_LIT, b);
                end
                restart_text();
            end
            slwm_pkg::OP_QUERY: begin
                restart_text();
                r.match    = (tk_cnt == 0) && !ovf_seen;
                r.too_long = ovf_seen;
                match_q.push_back(r);
            end
            default: begin
                if (!txt_busy) begin
                    restart_text();
                end
                nxt = '0;
                for (int i = 0; i < tk_cnt; i++) begin
                    if (act_pos[i]) begin
                        if (tk_kind[i] == slwm_pkg::KIND_RUN) begin
                            nxt[i] = 1'b1;
                        end else if (tk_kind[i] == slwm_pkg::KIND_ONE) begin
                            nxt[i + 1] = 1'b1;
                        end else if (case_fold(tk_char[i]) == case_fold(b)) begin
                            nxt[i + 1] = 1'b1;
                        end
                    end
                end
                act_pos  = nxt;
                spread_runs();
                txt_busy = 1'b1;
                if (l) begin
                    r.match    = !ovf_seen && act_pos[tk_cnt];
                    r.too_long = ovf_seen;
                    match_q.push_back(r);
                    restart_text();
                end
            end
        endcase
    endfunction

    // Send one word; valid stays high when the next word follows at once
    task automatic send_word(input slwm_pkg::t_opcode op, input logic [7:0] b, input logic l);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.opcode    <= op;
        in_if.data_byte <= b;
        in_if.last      <= l;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        predict_word(op, b, l);
        sent_cnt++;
    endtask

    // Empty text goes out as a query
    task automatic send_text(input t_octet_q t);
        if (t.size() == 0) begin
            send_word(slwm_pkg::OP_QUERY, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end else begin
            foreach (t[i]) begin
                send_word(slwm_pkg::OP_TEXT, t[i], i == t.size() - 1);
            end
        end
    endtask

    task automatic send_pattern(input t_octet_q p);
        send_word(slwm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        foreach (p[i]) begin
            send_word(slwm_pkg::OP_APPEND, p[i], 1'($urandom_range(0, 1)));
        end
    endtask

    // Drop valid, wait for all results, then let the pipeline empty
    task automatic drain_results();
        int w;
        w = 0;
        in_if.valid <= 1'b0;
        while ((match_q.size() != 0) && (w < DRAIN_LIMIT)) begin
            @(posedge i_clk);
            w++;
        end
        if (match_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, match_q.size());
            n_err++;
            match_q.delete();
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Write ignore_case, then read it back
    task automatic cfg_write(input logic v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FOLD;
        pwdata  <= {31'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        fold_en = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[0] !== v) begin
            $display("%0t: ignore_case readback expected %0b actual %0b", $time, v, prdata[0]);
            n_err++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] pick_pat_byte();
        case ($urandom_range(0, 9))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h41;
            3: return 8'h5A;
            4: return slwm_pkg::CH_RUN;
            5: return slwm_pkg::CH_ONE;
            6: return slwm_pkg::CH_ESC;
            7: return 8'h00;
            8: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 7))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h41;
            3: return 8'h42;
            4: return 8'h7A;
            5: return 8'h5A;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Build a text that the current pattern most likely matches
    function automatic t_octet_q text_from_pattern();
        t_octet_q t;
        logic [7:0] c;
        int i;
        i = 0;
        while (i < pat_q.size()) begin
            c = pat_q[i];
            if (c == slwm_pkg::CH_ESC) begin
                if (i + 1 < pat_q.size()) begin
                    t.push_back(pat_q[i + 1]);
                    i++;
                end else begin
                    t.push_back(slwm_pkg::CH_ESC);
                end
            end else if (c == slwm_pkg::CH_RUN) begin
                repeat ($urandom_range(0, 2)) t.push_back(pick_text_byte());
            end else if (c == slwm_pkg::CH_ONE) begin
                t.push_back(pick_text_byte());
            end else if (is_letter(c) && $urandom_range(0, 1)) begin
                t.push_back(c ^ 8'h20);
            end else begin
                t.push_back(c);
            end
            i++;
        end
        if ((t.size() > 0) && ($urandom_range(0, 4) == 0)) begin
            t[$urandom_range(0, t.size() - 1)] = pick_text_byte();
        end
        return t;
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_like_res e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (match_q.size() == 0) begin
                $display("%0t: result with none expected, match %0b too_long %0b",
                         $time, out_if.match, out_if.pattern_too_long);
                n_err++;
            end else begin
                e = match_q.pop_front();
                if (out_if.match !== e.match) begin
                    $display("%0t: match expected %0b actual %0b",
                             $time, e.match, out_if.match);
                    n_err++;
                end
                if (out_if.pattern_too_long !== e.too_long) begin
                    $display("%0t: pattern_too_long expected %0b actual %0b",
                             $time, e.too_long, out_if.pattern_too_long);
                    n_err++;
                end
            end
        end
    end

    // Result-side back pressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Empty pattern, runs, one-byte wildcards, escapes, abandoned text
    task automatic test_basics();
        send_word(slwm_pkg::OP_QUERY, 8'hFF, 1'b1);
        send_word(slwm_pkg::OP_APPEND, slwm_pkg::CH_RUN, 1'b1);
        send_word(slwm_pkg::OP_QUERY, 8'h00, 1'b0);
        send_word(slwm_pkg::OP_TEXT, 8'h00, 1'b1);
        send_word(slwm_pkg::OP_APPEND, slwm_pkg::CH_RUN, 1'b0);
        send_word(slwm_pkg::OP_TEXT, 8'hFF, 1'b1);
        send_pattern('{8'h61, slwm_pkg::CH_ONE, 8'hFF});
        send_text('{8'h61, 8'h00, 8'hFF});
        send_text('{8'h61, 8'h62});
        send_pattern('{slwm_pkg::CH_ESC, slwm_pkg::CH_RUN});
        send_text('{slwm_pkg::CH_RUN});
        send_text('{8'h78});
        send_pattern('{slwm_pkg::CH_ESC});
        send_text('{slwm_pkg::CH_ESC});
        // escape still pending: this byte replaces the backslash
        send_word(slwm_pkg::OP_APPEND, 8'h71, 1'b1);
        send_word(slwm_pkg::OP_TEXT, 8'h71, 1'b0);
        send_word(slwm_pkg::OP_QUERY, 8'h71, 1'b1);
        send_word(slwm_pkg::OP_TEXT, 8'h71, 1'b0);
        send_word(slwm_pkg::OP_APPEND, 8'h72, 1'b0);
        send_text('{8'h71, 8'h72});
        drain_results();
    endtask

    // Letter folding at the edges of the upper-case range
    task automatic test_case_fold();
        cfg_write(1'b1);
        send_pattern('{8'h41, 8'h7A, slwm_pkg::CH_RUN});
        send_text('{8'h61, 8'h5A});
        send_text('{8'h5B, 8'h7A});
        send_text('{8'h40, 8'h5A, 8'h41});
        drain_results();
        cfg_write(1'b0);
        send_text('{8'h61, 8'h7A});
        send_text('{8'h41, 8'h7A, 8'h00});
        drain_results();
    endtask

    // Full token store: escaped last token, overflow by byte and by backslash
    task automatic test_overflow();
        t_octet_q t;
        send_word(slwm_pkg::OP_CLEAR, 8'h00, 1'b0);
        repeat (MAXT - 1) send_word(slwm_pkg::OP_APPEND, slwm_pkg::CH_ONE, 1'b0);
        send_word(slwm_pkg::OP_APPEND, slwm_pkg::CH_ESC, 1'b0);
        send_word(slwm_pkg::OP_APPEND, slwm_pkg::CH_RUN, 1'b0);
        repeat (MAXT - 1) t.push_back(8'($urandom_range(0, 255)));
        t.push_back(slwm_pkg::CH_RUN);
        send_text(t);
        send_word(slwm_pkg::OP_APPEND, 8'h62, 1'b0);
        send_text(t);
        send_word(slwm_pkg::OP_QUERY, 8'h00, 1'b0);
        send_word(slwm_pkg::OP_CLEAR, 8'hFF, 1'b1);
        repeat (MAXT) send_word(slwm_pkg::OP_APPEND, slwm_pkg::CH_ONE, 1'b0);
        send_word(slwm_pkg::OP_APPEND, slwm_pkg::CH_ESC, 1'b0);
        send_word(slwm_pkg::OP_QUERY, 8'h00, 1'b0);
        send_word(slwm_pkg::OP_CLEAR, 8'h00, 1'b0);
        send_word(slwm_pkg::OP_QUERY, 8'h00, 1'b0);
        drain_results();
    endtask

    // Mostly patterns followed by texts, with noise words mixed in
    task automatic test_random(input int idle_pct, input int stall_pct, input logic fold,
                               input int n_items);
        int goal;
        int r;
        int len;
        t_octet_q t;
        cfg_write(fold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = sent_cnt + n_items;
        while (sent_cnt < goal) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_word(slwm_pkg::t_opcode'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (r < 20) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68)
                                                    : $urandom_range(0, 8);
                pat_q.delete();
                repeat (len) pat_q.push_back(pick_pat_byte());
                send_pattern(pat_q);
            end else if (r < 25) begin
                send_word(slwm_pkg::OP_QUERY, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else if (r < 70) begin
                send_text(text_from_pattern());
            end else begin
                t.delete();
                repeat ($urandom_range(0, 6)) t.push_back(pick_text_byte());
                send_text(t);
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.opcode    <= slwm_pkg::OP_CLEAR;
        in_if.data_byte <= 8'h00;
        in_if.last      <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= ADDR_FOLD;
        pwdata          <= 32'd0;
        n_err           = 0;
        sent_cnt        = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        matcher_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basics();
        test_case_fold();
        test_overflow();
        test_random(0, 0, 1'b0, 250);
        test_random(59, 0, 1'b1, 250);
        test_random(0, 59, 1'b0, 250);
        test_random(30, 30, 1'b1, 250);

        if (n_err == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/slwm_pkg.sv
rtl/core/slwm_in_if.sv
rtl/core/slwm_out_if.sv
rtl/core/slwm_nfa.sv
rtl/core/sql_like_wildcard_matcher_top.sv
verif/tb.sv
